[design/mme_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers of the matrix multiply engine.
// No dependencies.
package mme_pkg;

    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = 4;
    localparam int DIM_W     = 5;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int RES_W     = 32;
    localparam int DRAIN_CYC = MAX_DIM + 3;
    localparam int DRAIN_W   = $clog2(DRAIN_CYC + 1);

    localparam logic [1:0] MODE_WR_A = 2'd0;
    localparam logic [1:0] MODE_WR_B = 2'd1;
    localparam logic [1:0] MODE_ROW  = 2'd2;

    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_COLS_B = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // Operand moving along the cell chain.
    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         k;
        logic signed [ELEM_W-1:0] a;
    } mme_link_t;

    // Broadcast control to every cell.
    typedef struct packed {
        logic                     clear;
        logic                     shift;
        logic                     b_wr;
        logic [IDX_W-1:0]         b_row;
        logic [IDX_W-1:0]         b_col;
        logic signed [ELEM_W-1:0] b_data;
    } mme_ctl_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        eff_dim = (r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r;
    endfunction

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi)
        begin
            sat_res = RES_W'(32'h7fffffff);
        end
        else if (v < lo)
        begin
            sat_res = RES_W'(32'h80000000);
        end
        else
        begin
            sat_res = v[RES_W-1:0];
        end
    endfunction

endpackage

[design/mme_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the matrix multiply engine.
// Depends on mme_pkg.
interface mme_in_if import mme_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
    modport source (output valid, mode, row_index, col_index, element_value, input ready);
    modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

interface mme_out_if import mme_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [RES_W-1:0] product_value;
    logic                    last;
    modport source (output valid, out_row, out_col, product_value, last, input ready);
    modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

[design/mme_cell.sv]
`timescale 1ns / 1ps
// One multiply-accumulate cell: owns one column of B and one accumulator.
// Depends on mme_pkg.
module mme_cell
    import mme_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [IDX_W-1:0]        col_id,
    input  mme_ctl_t                ctl,
    input  mme_link_t               link_in,
    output mme_link_t               link_out,
    input  logic signed [ACC_W-1:0] acc_in,
    output logic signed [ACC_W-1:0] acc_out
);

    logic signed [ELEM_W-1:0] b_mem_reg [MAX_DIM];
    mme_link_t                link_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.b_wr && ctl.b_col == col_id)
        begin
            b_mem_reg[ctl.b_row] <= ctl.b_data;
        end
        prod_reg <= link_in.a * b_mem_reg[link_in.k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
            pv_reg   <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            link_reg <= link_in;
            pv_reg   <= link_in.valid;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            else if (ctl.shift)
            begin
                acc_reg <= acc_in;
            end
        end
    end

    assign link_out = link_reg;
    assign acc_out  = acc_reg;

endmodule

[design/matrix_multiply_engine_unit.sv]
`timescale 1ns / 1ps
// Matrix multiply engine: element writes are taken one per cycle while idle.
// A row request passes through the feed and drain states along the chain of 16
// MAC cells (straight to output when inner_dim is 0), then gives cols_b results
// one per accepted output cycle. No item is taken until the row is out.
// rst_n (async, low) returns control to idle and dimensions to 16; stores are
// not cleared.
module matrix_multiply_engine_unit
    import mme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mme_in_if.sink       in_ch,
    mme_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_FEED, ST_DRAIN, ST_OUT} state_t;

    state_t              state_reg;
    logic [DIM_W-1:0]    rows_a_reg, inner_reg, cols_b_reg;
    logic [IDX_W-1:0]    row_reg, k_reg, col_reg;
    logic [DRAIN_W-1:0]  drain_reg;
    logic                feed_v_reg;
    logic [IDX_W-1:0]    feed_k_reg;
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] a_mem [MAX_DIM * MAX_DIM];

    logic [DIM_W-1:0]    m_eff, kd_eff, n_eff;
    logic                in_acc, out_acc, cfg_wr, feeding;
    mme_ctl_t            ctl;
    mme_link_t           link [MAX_DIM + 1];
    logic signed [ACC_W-1:0] acc_w [MAX_DIM + 1];

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS_A: prdata = 32'(rows_a_reg);
            REG_INNER:  prdata = 32'(inner_reg);
            REG_COLS_B: prdata = 32'(cols_b_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_RESET;
            inner_reg  <= DIM_RESET;
            cols_b_reg <= DIM_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROWS_A: rows_a_reg <= pwdata[DIM_W-1:0];
                REG_INNER:  inner_reg  <= pwdata[DIM_W-1:0];
                REG_COLS_B: cols_b_reg <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    assign m_eff  = eff_dim(rows_a_reg);
    assign kd_eff = eff_dim(inner_reg);
    assign n_eff  = eff_dim(cols_b_reg);

    // Handshakes: input taken only when idle; output shown while streaming.
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_acc     = out_ch.valid && out_ch.ready;
    assign feeding     = (state_reg == ST_FEED);

    // A store: one write port, one registered read port walking row_reg.
    always_ff @(posedge clk)
    begin
        if (in_acc && in_ch.mode == MODE_WR_A
            && {1'b0, in_ch.row_index} < m_eff && {1'b0, in_ch.col_index} < kd_eff)
        begin
            a_mem[{in_ch.row_index, in_ch.col_index}] <= in_ch.element_value;
        end
        a_rd_reg   <= a_mem[{row_reg, k_reg}];
        feed_k_reg <= k_reg;
    end

    // Broadcast control; B writes go to the cell that owns the column.
    always_comb
    begin
        ctl.clear  = in_acc && in_ch.mode == MODE_ROW;
        ctl.shift  = out_acc;
        ctl.b_wr   = in_acc && in_ch.mode == MODE_WR_B
                     && {1'b0, in_ch.row_index} < kd_eff
                     && {1'b0, in_ch.col_index} < n_eff;
        ctl.b_row  = in_ch.row_index;
        ctl.b_col  = in_ch.col_index;
        ctl.b_data = in_ch.element_value;
    end

    // Operand enters cell 0 and ripples one cell per cycle.
    assign link[0].valid = feed_v_reg;
    assign link[0].k     = feed_k_reg;
    assign link[0].a     = a_rd_reg;
    assign acc_w[MAX_DIM] = '0;

    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        mme_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .col_id   (IDX_W'(j)),
            .ctl      (ctl),
            .link_in  (link[j]),
            .link_out (link[j + 1]),
            .acc_in   (acc_w[j + 1]),
            .acc_out  (acc_w[j])
        );
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            k_reg      <= '0;
            col_reg    <= '0;
            drain_reg  <= '0;
            feed_v_reg <= 1'b0;
        end
        else
        begin
            feed_v_reg <= feeding;
            case (state_reg)
                ST_IDLE:
                begin
                    k_reg   <= '0;
                    col_reg <= '0;
                    if (in_acc && in_ch.mode == MODE_ROW
                        && {1'b0, in_ch.row_index} < m_eff && n_eff != '0)
                    begin
                        row_reg   <= in_ch.row_index;
                        drain_reg <= '0;
                        state_reg <= (kd_eff == '0) ? ST_OUT : ST_FEED;
                    end
                end
                ST_FEED:
                begin
                    k_reg <= k_reg + 1'b1;
                    if ({1'b0, k_reg} == kd_eff - 1'b1)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == DRAIN_W'(DRAIN_CYC - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        col_reg <= col_reg + 1'b1;
                        if (out_ch.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Results leave from cell 0; the chain shifts on each accepted result.
    assign out_ch.valid         = (state_reg == ST_OUT);
    assign out_ch.out_row       = row_reg;
    assign out_ch.out_col       = col_reg;
    assign out_ch.product_value = sat_res(acc_w[0]);
    assign out_ch.last          = ({1'b0, col_reg} == n_eff - 1'b1);

endmodule

[design/mme_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the matrix multiply engine, bound to the top level.
// Depends on mme_pkg.
module mme_checker
    import mme_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    out_last,
    input logic [IDX_W-1:0]        out_col,
    input logic signed [RES_W-1:0] product_value
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while results pending");

    a_end_of_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid && in_ready)
        else $error("results continue after last");

    a_row_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid && out_col == $past(out_col) + 1'b1)
        else $error("row broken off");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(product_value) && $stable(out_col))
        else $error("stalled result changed");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_last      (out_ch.last),
    .out_col       (out_ch.out_col),
    .product_value (out_ch.product_value)
);
